/* sv/assert_macros.svh */
// Assertion macros shared by the console interpreter RTL.
// All checks are clocked on i_clk and disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every edge out of reset.
`define TCCI_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition on one edge that implies another condition at the next edge.
`define TCCI_ASSERT_NEXT(name, cause, effect, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cause) |=> (effect)) else $error(msg);

`endif

/* sv/tcci_pkg.sv */
// Package for the text console control interpreter: control byte codes,
// display command codes, escape modes and the state and command structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcci_pkg;

    // Display geometry limits
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 128;

    // Reset values of the geometry registers
    localparam logic [6:0] ROWS_RESET = 7'd24;
    localparam logic [7:0] COLS_RESET = 8'd80;

    // Configuration register indexes
    localparam logic [1:0] CFG_ROWS = 2'd0;
    localparam logic [1:0] CFG_COLS = 2'd1;

    // Control bytes
    localparam logic [7:0] CH_LOCATE  = 8'd1;
    localparam logic [7:0] CH_HOME    = 8'd2;
    localparam logic [7:0] CH_CLEAR   = 8'd3;
    localparam logic [7:0] CH_FORWARD = 8'd4;
    localparam logic [7:0] CH_EOL     = 8'd5;
    localparam logic [7:0] CH_UP      = 8'd6;
    localparam logic [7:0] CH_BELL    = 8'd7;
    localparam logic [7:0] CH_BACK    = 8'd8;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_REV_ON  = 8'd11;
    localparam logic [7:0] CH_REV_OFF = 8'd12;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_SAVE    = 8'd14;
    localparam logic [7:0] CH_RESTORE = 8'd15;
    localparam logic [7:0] CH_INS     = 8'd16;
    localparam logic [7:0] CH_DEL     = 8'd17;

    // Printable range and locate offset
    localparam logic [7:0] PRINT_LO      = 8'h20;
    localparam logic [7:0] PRINT_HI      = 8'hfd;
    localparam logic [7:0] LOCATE_OFFSET = 8'h20;
    localparam logic [6:0] TAB_MASK      = 7'h07;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ROW    = 2'd1,
        MODE_COL    = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        CMD_PAINT  = 3'd0,
        CMD_CURSOR = 3'd1,
        CMD_CLEAR  = 3'd2,
        CMD_EOL    = 3'd3,
        CMD_DELETE = 3'd4,
        CMD_INSERT = 3'd5,
        CMD_BELL   = 3'd6
    } t_cmd_code;

    typedef struct packed {
        t_mode      mode;
        logic [5:0] row;
        logic [6:0] col;
        logic [5:0] saved_row;
        logic [6:0] saved_col;
        logic       standout;
    } t_state;

    typedef struct packed {
        t_cmd_code  code;
        logic [5:0] row;
        logic [6:0] col;
        logic [7:0] glyph;
        logic       rev;
        logic [9:0] px;
        logic [9:0] py;
    } t_result;

endpackage

`default_nettype wire

/* sv/tcci_step.sv */
// Combinational interpreter step: from the current console state and one
// byte, gives the next state and up to three display commands in order.
// Depends on tcci_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcci_step
    import tcci_pkg::*;
(
    input  wire logic [7:0]    i_byte,
    input  wire t_state        i_state,
    input  wire logic [6:0]    i_rows,
    input  wire logic [7:0]    i_cols,
    output t_state             o_state,
    output t_result [2:0]      o_res,
    output logic [1:0]         o_count
);

    function automatic t_result mk(t_cmd_code code, logic [5:0] row, logic [6:0] col,
                                   logic [7:0] glyph, logic rev,
                                   logic [9:0] px, logic [9:0] py);
        t_result r;
        r.code  = code;
        r.row   = row;
        r.col   = col;
        r.glyph = glyph;
        r.rev   = rev;
        r.px    = px;
        r.py    = py;
        return r;
    endfunction

    // Effective geometry: zero acts as one, oversize acts as the limit
    logic [6:0] rows_eff;
    logic [7:0] cols_eff;
    logic [5:0] rows_last;
    logic [6:0] cols_last;

    always_comb begin
        if (i_rows == 7'd0) begin
            rows_eff = 7'd1;
        end else if (i_rows > 7'(MAX_ROWS)) begin
            rows_eff = 7'(MAX_ROWS);
        end else begin
            rows_eff = i_rows;
        end
        if (i_cols == 8'd0) begin
            cols_eff = 8'd1;
        end else if (i_cols > 8'(MAX_COLS)) begin
            cols_eff = 8'(MAX_COLS);
        end else begin
            cols_eff = i_cols;
        end
        rows_last = 6'(rows_eff - 7'd1);
        cols_last = 7'(cols_eff - 8'd1);
    end

    // Line feed and advance, computed from the current position
    logic [6:0] row_p1;
    logic [7:0] col_p1;
    logic       nl_scroll;
    logic [5:0] nl_row;
    logic       adv_wrap;
    logic [6:0] adv_col;
    logic [5:0] adv_row;
    logic       adv_scroll;
    logic [7:0] tab_next;
    logic [6:0] tab_col;
    logic [7:0] loc_val;

    always_comb begin
        row_p1     = {1'b0, i_state.row} + 7'd1;
        nl_scroll  = (row_p1 >= rows_eff);
        nl_row     = nl_scroll ? i_state.row : row_p1[5:0];
        col_p1     = {1'b0, i_state.col} + 8'd1;
        adv_wrap   = (col_p1 >= cols_eff);
        adv_col    = adv_wrap ? 7'd0 : col_p1[6:0];
        adv_row    = adv_wrap ? nl_row : i_state.row;
        adv_scroll = adv_wrap && nl_scroll;
        // next multiple of 8, clamped at the last column
        tab_next   = {1'b0, i_state.col | TAB_MASK} + 8'd1;
        tab_col    = (tab_next >= cols_eff) ? cols_last : tab_next[6:0];
        loc_val    = i_byte - LOCATE_OFFSET;
    end

    // Decode: next state and which commands fire
    t_state st;
    logic   e_paint;
    logic   e_clear;
    logic   e_scroll;
    logic   e_eol;
    logic   e_bell;
    logic   e_insert;
    logic   e_delrow;
    logic   e_cursor;

    always_comb begin
        st       = i_state;
        e_paint  = 1'b0;
        e_clear  = 1'b0;
        e_scroll = 1'b0;
        e_eol    = 1'b0;
        e_bell   = 1'b0;
        e_insert = 1'b0;
        e_delrow = 1'b0;
        e_cursor = 1'b0;
        case (i_state.mode)
            MODE_ROW: begin
                st.row  = (loc_val >= {1'b0, rows_eff}) ? rows_last : loc_val[5:0];
                st.mode = MODE_COL;
            end
            MODE_COL: begin
                st.col   = (loc_val >= cols_eff) ? cols_last : loc_val[6:0];
                st.mode  = MODE_NORMAL;
                e_cursor = 1'b1;
            end
            default: begin
                st.mode = MODE_NORMAL;
                case (i_byte)
                    CH_LOCATE: begin
                        st.mode = MODE_ROW;
                    end
                    CH_HOME: begin
                        st.row   = 6'd0;
                        st.col   = 7'd0;
                        e_cursor = 1'b1;
                    end
                    CH_CLEAR: begin
                        st.row   = 6'd0;
                        st.col   = 7'd0;
                        e_clear  = 1'b1;
                        e_cursor = 1'b1;
                    end
                    CH_FORWARD: begin
                        st.row   = adv_row;
                        st.col   = adv_col;
                        e_scroll = adv_scroll;
                        e_cursor = 1'b1;
                    end
                    CH_EOL: begin
                        e_eol = 1'b1;
                    end
                    CH_UP: begin
                        if (i_state.row != 6'd0) begin
                            st.row = i_state.row - 6'd1;
                        end
                        e_cursor = 1'b1;
                    end
                    CH_BELL: begin
                        e_bell = 1'b1;
                    end
                    CH_BACK: begin
                        if (i_state.col != 7'd0) begin
                            st.col = i_state.col - 7'd1;
                        end
                        e_cursor = 1'b1;
                    end
                    CH_TAB: begin
                        st.col   = tab_col;
                        e_cursor = 1'b1;
                    end
                    CH_LF: begin
                        st.row   = nl_row;
                        e_scroll = nl_scroll;
                        e_cursor = 1'b1;
                    end
                    CH_REV_ON: begin
                        st.standout = 1'b1;
                    end
                    CH_REV_OFF: begin
                        st.standout = 1'b0;
                    end
                    CH_CR: begin
                        st.col   = 7'd0;
                        e_cursor = 1'b1;
                    end
                    CH_SAVE: begin
                        st.saved_row = i_state.row;
                        st.saved_col = i_state.col;
                    end
                    CH_RESTORE: begin
                        st.row   = i_state.saved_row;
                        st.col   = i_state.saved_col;
                        e_cursor = 1'b1;
                    end
                    CH_INS: begin
                        e_insert = 1'b1;
                    end
                    CH_DEL: begin
                        e_delrow = 1'b1;
                    end
                    default: begin
                        // other bytes paint when printable and always advance
                        e_paint  = (i_byte >= PRINT_LO) && (i_byte <= PRINT_HI);
                        st.row   = adv_row;
                        st.col   = adv_col;
                        e_scroll = adv_scroll;
                        e_cursor = 1'b1;
                    end
                endcase
            end
        endcase
    end

    // Pack the commands in display order
    t_result [2:0] res;
    logic [1:0]    cnt;

    always_comb begin
        res = '0;
        cnt = 2'd0;
        if (e_paint) begin
            res[cnt] = mk(CMD_PAINT, i_state.row, i_state.col, i_byte, i_state.standout,
                          10'd0, 10'd0);
            cnt = cnt + 2'd1;
        end
        if (e_clear) begin
            res[cnt] = mk(CMD_CLEAR, 6'd0, 7'd0, 8'd0, 1'b0, 10'd0, 10'd0);
            cnt = cnt + 2'd1;
        end
        if (e_scroll) begin
            res[cnt] = mk(CMD_DELETE, 6'd0, 7'd0, 8'd0, 1'b0, 10'd0, 10'd0);
            cnt = cnt + 2'd1;
        end
        if (e_eol) begin
            res[cnt] = mk(CMD_EOL, i_state.row, i_state.col, 8'd0, 1'b0, 10'd0, 10'd0);
            cnt = cnt + 2'd1;
        end
        if (e_bell) begin
            res[cnt] = mk(CMD_BELL, 6'd0, 7'd0, 8'd0, 1'b0, 10'd0, 10'd0);
            cnt = cnt + 2'd1;
        end
        if (e_insert) begin
            res[cnt] = mk(CMD_INSERT, i_state.row, 7'd0, 8'd0, 1'b0, 10'd0, 10'd0);
            cnt = cnt + 2'd1;
        end
        if (e_delrow) begin
            res[cnt] = mk(CMD_DELETE, i_state.row, 7'd0, 8'd0, 1'b0, 10'd0, 10'd0);
            cnt = cnt + 2'd1;
        end
        if (e_cursor) begin
            // x = col * 8, y = row * 16 - row
            res[cnt] = mk(CMD_CURSOR, st.row, st.col, 8'd0, 1'b0, {st.col, 3'b000},
                          {st.row, 4'b0000} - {4'b0000, st.row});
            cnt = cnt + 2'd1;
        end
    end

    assign o_state = st;
    assign o_res   = res;
    assign o_count = cnt;

endmodule

`default_nettype wire

/* sv/text_console_control_interpreter.sv */
// Text console control interpreter: one input byte in, a run of display
// commands out.
//
// Channels: the byte channel (i_in_valid, o_in_stall, i_byte_in) and the
// command channel (o_out_valid, i_out_stall and the command fields). A
// transfer happens on an edge with valid high and stall low. The config
// channel (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data) writes the
// row count at index 0 and the column count at index 1; it is always ready.
// A taken byte sits in the input register until the command register can
// hold its run; it is then decoded and the first command of its run is
// valid; later commands of the run follow one per cycle while the output
// does not stall, the last one flagged by o_last_of_run. Bytes pass one
// per cycle while each yields at most one command and the output does
// not stall; a byte yields 0 to 3 commands, and the next byte is decoded
// only as that run drains. Stall: a byte waits in the input register and o_in_stall rises while
// the command register cannot empty at this edge (more than one command
// left, or its last command stalled). Reset returns the cursor, saved
// position and standout flag to zero, the escape mode to normal and the
// geometry to 24 rows by 80 cols.
// Depends on tcci_pkg, tcci_step and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module text_console_control_interpreter
    import tcci_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // byte input channel
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_byte_in,
    // command output channel
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [2:0]      o_command,
    output logic [5:0]      o_text_row,
    output logic [6:0]      o_text_col,
    output logic [7:0]      o_glyph,
    output logic            o_reverse_video,
    output logic [9:0]      o_pixel_x,
    output logic [9:0]      o_pixel_y,
    output logic            o_last_of_run,
    // configuration write channel
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    // Geometry registers
    logic [6:0] r_rows;
    logic [7:0] r_cols;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ROWS_RESET;
            r_cols <= COLS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ROWS: r_rows <= i_cfg_data[6:0];
                CFG_COLS: r_cols <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // Handshake control
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_result [2:0] r_slot;
    logic [1:0] r_cnt;
    t_state     r_st;

    logic take;
    logic slot_free;
    logic adv;
    logic in_xfer;

    assign take       = (r_cnt != 2'd0) && !i_out_stall;
    assign slot_free  = (r_cnt == 2'd0) || (take && (r_cnt == 2'd1));
    assign adv        = r_in_valid && slot_free;
    assign o_in_stall = r_in_valid && !slot_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // Decode of the held byte
    t_state        n_st;
    t_result [2:0] n_res;
    logic [1:0]    n_cnt;

    tcci_step u_step (
        .i_byte  (r_in_byte),
        .i_state (r_st),
        .i_rows  (r_rows),
        .i_cols  (r_cols),
        .o_state (n_st),
        .o_res   (n_res),
        .o_count (n_cnt)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_byte_in;
        end
    end

    // Console state, committed when the byte is decoded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '{mode: MODE_NORMAL, row: 6'd0, col: 7'd0,
                      saved_row: 6'd0, saved_col: 7'd0, standout: 1'b0};
        end else if (adv) begin
            r_st <= n_st;
        end
    end

    // Command register: slot 0 is on the port, later slots shift down
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (adv) begin
            r_cnt <= n_cnt;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_slot <= n_res;
        end else if (take) begin
            r_slot <= {{$bits(t_result){1'b0}}, r_slot[2:1]};
        end
    end

    // Output fields
    assign o_out_valid     = (r_cnt != 2'd0);
    assign o_command       = r_slot[0].code;
    assign o_text_row      = r_slot[0].row;
    assign o_text_col      = r_slot[0].col;
    assign o_glyph         = r_slot[0].glyph;
    assign o_reverse_video = r_slot[0].rev;
    assign o_pixel_x       = r_slot[0].px;
    assign o_pixel_y       = r_slot[0].py;
    assign o_last_of_run   = (r_cnt == 2'd1);

    // Checks
    `TCCI_ASSERT_NEXT(a_hold_byte, r_in_valid && !slot_free, r_in_valid && $stable(r_in_byte), "held byte lost while command register busy")
    `TCCI_ASSERT_NEXT(a_run_continues, take && (r_cnt > 2'd1), o_out_valid, "command run broken before its last command")
    `TCCI_ASSERT_NEXT(a_row_byte_quiet, adv && (r_st.mode == MODE_ROW), (r_cnt == 2'd0) && (r_st.mode == MODE_COL), "locate row byte must yield nothing and await column")
    `TCCI_ASSERT(a_no_run_overlap, !(adv && take && (r_cnt > 2'd1)), "new run loaded over pending commands")

endmodule

`default_nettype wire

/* dv/tb_text_console_control_interpreter.sv */
// Self-checking testbench for text_console_control_interpreter: directed bytes from a
// table, then random byte streams under several display geometries and idle patterns.
// Depends on tcci_pkg and the interpreter RTL.
`timescale 1ns / 1ps

module tb_text_console_control_interpreter;
    import tcci_pkg::*;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 11;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_CYCLES     = 60;
    localparam int ITEMS_PER_PHASE = 17;
    localparam int NUM_PHASES      = 7;
    localparam int NUM_DIRECTED    = 30;
    // run time limit; it leaves a wide margin
    localparam int RUN_LIMIT_NS    = 2_000_000;
    // index with no register behind it
    localparam logic [1:0] CFG_SPARE = 2'd3;

    // one display command as seen on the output channel
    typedef struct packed {
        t_cmd_code  code;
        logic [5:0] row;
        logic [6:0] col;
        logic [7:0] glyph;
        logic       rev;
        logic [9:0] px;
        logic [9:0] py;
        logic       last;
    } t_disp_cmd;

    // directed row: byte, and for single-command bytes an optional fixed answer
    typedef struct packed {
        logic [7:0] ch;
        logic       fixed;
        t_cmd_code  code;
        logic [5:0] row;
        logic [6:0] col;
        logic [9:0] px;
        logic [9:0] py;
    } t_stim_row;

    // walked from reset with the 24 x 80 default geometry
    localparam t_stim_row DIRECTED [NUM_DIRECTED] = '{
        '{CH_RESTORE, 1'b1, CMD_CURSOR, 6'd0,  7'd0,  10'd0,   10'd0},
        '{CH_BELL,    1'b1, CMD_BELL,   6'd0,  7'd0,  10'd0,   10'd0},
        '{CH_EOL,     1'b1, CMD_EOL,    6'd0,  7'd0,  10'd0,   10'd0},
        '{8'h00,      1'b0, CMD_PAINT,  6'd0,  7'd0,  10'd0,   10'd0},
        '{PRINT_LO,   1'b0, CMD_PAINT,  6'd0,  7'd0,  10'd0,   10'd0},
        '{PRINT_HI,   1'b0, CMD_PAINT,  6'd0,  7'd0,  10'd0,   10'd0},
        '{8'hfe,      1'b0, CMD_PAINT,  6'd0,  7'd0,  10'd0,   10'd0},
        '{8'hff,      1'b0, CMD_PAINT,  6'd0,  7'd0,  10'd0,   10'd0},
        '{CH_REV_ON,  1'b0, CMD_PAINT,  6'd0,  7'd0,  10'd0,   10'd0},
        '{8'h41,      1'b0, CMD_PAINT,  6'd0,  7'd0,  10'd0,   10'd0},
        '{CH_REV_OFF, 1'b0, CMD_PAINT,  6'd0,  7'd0,  10'd0,   10'd0},
        '{CH_LOCATE,  1'b0, CMD_PAINT,  6'd0,  7'd0,  10'd0,   10'd0},
        '{8'hff,      1'b0, CMD_PAINT,  6'd0,  7'd0,  10'd0,   10'd0},
        '{8'h1f,      1'b1, CMD_CURSOR, 6'd23, 7'd79, 10'd632, 10'd345},
        '{CH_SAVE,    1'b0, CMD_PAINT,  6'd0,  7'd0,  10'd0,   10'd0},
        '{CH_FORWARD, 1'b0, CMD_PAINT,  6'd0,  7'd0,  10'd0,   10'd0},
        '{CH_LF,      1'b0, CMD_PAINT,  6'd0,  7'd0,  10'd0,   10'd0},
        '{CH_RESTORE, 1'b1, CMD_CURSOR, 6'd23, 7'd79, 10'd632, 10'd345},
        '{CH_TAB,     1'b0, CMD_PAINT,  6'd0,  7'd0,  10'd0,   10'd0},
        '{CH_BACK,    1'b0, CMD_PAINT,  6'd0,  7'd0,  10'd0,   10'd0},
        '{CH_UP,      1'b0, CMD_PAINT,  6'd0,  7'd0,  10'd0,   10'd0},
        '{CH_CR,      1'b0, CMD_PAINT,  6'd0,  7'd0,  10'd0,   10'd0},
        '{CH_INS,     1'b1, CMD_INSERT, 6'd22, 7'd0,  10'd0,   10'd0},
        '{CH_DEL,     1'b1, CMD_DELETE, 6'd22, 7'd0,  10'd0,   10'd0},
        '{CH_CLEAR,   1'b0, CMD_PAINT,  6'd0,  7'd0,  10'd0,   10'd0},
        '{CH_HOME,    1'b1, CMD_CURSOR, 6'd0,  7'd0,  10'd0,   10'd0},
        '{8'h1f,      1'b0, CMD_PAINT,  6'd0,  7'd0,  10'd0,   10'd0},
        '{CH_LOCATE,  1'b0, CMD_PAINT,  6'd0,  7'd0,  10'd0,   10'd0},
        '{8'h20,      1'b0, CMD_PAINT,  6'd0,  7'd0,  10'd0,   10'd0},
        '{8'h20,      1'b1, CMD_CURSOR, 6'd0,  7'd0,  10'd0,   10'd0}
    };

    // geometry per random phase: extremes, zero, out of range and a shrink
    localparam logic [7:0] PHASE_ROWS [NUM_PHASES] =
        '{8'd1, 8'd64, 8'd0, 8'hff, 8'd5, 8'd24, 8'd3};
    localparam logic [7:0] PHASE_COLS [NUM_PHASES] =
        '{8'd1, 8'd128, 8'd0, 8'hff, 8'd10, 8'd80, 8'd200};

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_byte_in   = 8'd0;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [1:0] i_cfg_index = 2'd0;
    logic [7:0] i_cfg_data  = 8'd0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [2:0] o_command;
    logic [5:0] o_text_row;
    logic [6:0] o_text_col;
    logic [7:0] o_glyph;
    logic       o_reverse_video;
    logic [9:0] o_pixel_x;
    logic [9:0] o_pixel_y;
    logic       o_last_of_run;
    logic       o_cfg_ready;

    text_console_control_interpreter u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_byte_in       (i_byte_in),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_command       (o_command),
        .o_text_row      (o_text_row),
        .o_text_col      (o_text_col),
        .o_glyph         (o_glyph),
        .o_reverse_video (o_reverse_video),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_last_of_run   (o_last_of_run),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // console state mirror
    t_mode      esc_mode    = MODE_NORMAL;
    int         cur_row     = 0;
    int         cur_col     = 0;
    int         mark_row    = 0;
    int         mark_col    = 0;
    logic       standout    = 1'b0;
    logic [6:0] rows_reg    = ROWS_RESET;
    logic [7:0] cols_reg    = COLS_RESET;

    t_disp_cmd  run_cmds[$];      // commands of the byte just taken
    t_disp_cmd  pending_cmds[$];  // commands still owed by the block
    t_disp_cmd  head_cmd;
    int         mismatches     = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    bit         hold_pending   = 1'b0;

    function automatic int rows_eff();
        if (rows_reg == 0) return 1;
        if (rows_reg > MAX_ROWS) return MAX_ROWS;
        return int'(rows_reg);
    endfunction

    function automatic int cols_eff();
        if (cols_reg == 0) return 1;
        if (cols_reg > MAX_COLS) return MAX_COLS;
        return int'(cols_reg);
    endfunction

    // at most three commands per byte; fields masked to port widths
    function automatic void add_cmd(t_cmd_code code, int row, int col, int glyph,
                                    logic rev, int px, int py);
        t_disp_cmd c;
        if (run_cmds.size() >= 3) return;
        c.code  = code;
        c.row   = row[5:0];
        c.col   = col[6:0];
        c.glyph = glyph[7:0];
        c.rev   = rev;
        c.px    = px[9:0];
        c.py    = py[9:0];
        c.last  = 1'b0;
        run_cmds.push_back(c);
    endfunction

    function automatic void add_cursor();
        add_cmd(CMD_CURSOR, cur_row, cur_col, 0, 1'b0, cur_col * 8, cur_row * 15);
    endfunction

    // bottom row scrolls by deleting line 0; the row itself stays
    function automatic void line_down();
        if (cur_row + 1 >= rows_eff()) add_cmd(CMD_DELETE, 0, 0, 0, 1'b0, 0, 0);
        else cur_row++;
    endfunction

    function automatic void step_right();
        cur_col++;
        if (cur_col >= cols_eff()) begin
            cur_col = 0;
            line_down();
        end
    endfunction

    // update the mirror for one byte and build its command run
    function automatic void console_step(logic [7:0] ch);
        logic [7:0] pos;
        pos = ch - LOCATE_OFFSET;
        run_cmds.delete();
        if (esc_mode == MODE_ROW) begin
            cur_row  = (pos >= rows_eff()) ? rows_eff() - 1 : int'(pos);
            esc_mode = MODE_COL;
            return;
        end
        if (esc_mode == MODE_COL) begin
            cur_col  = (pos >= cols_eff()) ? cols_eff() - 1 : int'(pos);
            esc_mode = MODE_NORMAL;
            add_cursor();
        end else begin
            esc_mode = MODE_NORMAL;
            case (ch)
                CH_LOCATE:  esc_mode = MODE_ROW;
                CH_HOME: begin
                    cur_row = 0;
                    cur_col = 0;
                    add_cursor();
                end
                CH_CLEAR: begin
                    cur_row = 0;
                    cur_col = 0;
                    add_cmd(CMD_CLEAR, 0, 0, 0, 1'b0, 0, 0);
                    add_cursor();
                end
                CH_FORWARD: begin
                    step_right();
                    add_cursor();
                end
                CH_EOL:     add_cmd(CMD_EOL, cur_row, cur_col, 0, 1'b0, 0, 0);
                CH_UP: begin
                    if (cur_row != 0) cur_row--;
                    add_cursor();
                end
                CH_BELL:    add_cmd(CMD_BELL, 0, 0, 0, 1'b0, 0, 0);
                CH_BACK: begin
                    if (cur_col != 0) cur_col--;
                    add_cursor();
                end
                CH_TAB: begin
                    // next tab stop, held at the last column
                    cur_col += 8 - (cur_col & TAB_MASK);
                    if (cur_col >= cols_eff()) cur_col = cols_eff() - 1;
                    add_cursor();
                end
                CH_LF: begin
                    line_down();
                    add_cursor();
                end
                CH_REV_ON:  standout = 1'b1;
                CH_REV_OFF: standout = 1'b0;
                CH_CR: begin
                    cur_col = 0;
                    add_cursor();
                end
                CH_SAVE: begin
                    mark_row = cur_row;
                    mark_col = cur_col;
                end
                CH_RESTORE: begin
                    cur_row = mark_row;
                    cur_col = mark_col;
                    add_cursor();
                end
                CH_INS:     add_cmd(CMD_INSERT, cur_row, 0, 0, 1'b0, 0, 0);
                CH_DEL:     add_cmd(CMD_DELETE, cur_row, 0, 0, 1'b0, 0, 0);
                default: begin
                    // unprintable bytes still move the cursor
                    if (ch >= PRINT_LO && ch <= PRINT_HI)
                        add_cmd(CMD_PAINT, cur_row, cur_col, ch, standout, 0, 0);
                    step_right();
                    add_cursor();
                end
            endcase
        end
        if (run_cmds.size() > 0) run_cmds[run_cmds.size() - 1].last = 1'b1;
    endfunction

    // locate argument: mostly inside the display, sometimes anything
    function automatic logic [7:0] locate_arg(int lim);
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
        return 8'(LOCATE_OFFSET + $urandom_range(0, lim));
    endfunction

    // offer one byte after a random gap, wait for the transfer, then predict
    task automatic offer_byte(input logic [7:0] ch, input logic fixed, input t_disp_cmd answer);
        int gap;
        gap = 0;
        while (gap < 16 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_byte_in  <= ch;
        do @(posedge i_clk); while (o_in_stall);
        console_step(ch);
        if (fixed) pending_cmds.push_back(answer);
        else foreach (run_cmds[k]) pending_cmds.push_back(run_cmds[k]);
    endtask

    // valid is left high; the caller lowers it after its last write
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_ROWS) rows_reg = data[6:0];
        else if (idx == CFG_COLS) cols_reg = data;
    endtask

    task automatic wait_quiet();
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // output side: random stall, plus one long hold on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // compare each command transfer with the oldest pending one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_cmds.size() == 0) begin
                $error("command %0d arrived with nothing pending", o_command);
                mismatches++;
            end else begin
                head_cmd = pending_cmds.pop_front();
                check_field("command", head_cmd.code, o_command);
                check_field("text_row", head_cmd.row, o_text_row);
                check_field("text_col", head_cmd.col, o_text_col);
                check_field("glyph", head_cmd.glyph, o_glyph);
                check_field("reverse_video", head_cmd.rev, o_reverse_video);
                check_field("pixel_x", head_cmd.px, o_pixel_x);
                check_field("pixel_y", head_cmd.py, o_pixel_y);
                check_field("last_of_run", head_cmd.last, o_last_of_run);
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        t_stim_row  srow;
        t_disp_cmd  answer;
        logic [7:0] ch;
        logic [7:0] locate_args[$];
        int         pick;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed bytes at the reset geometry, no idling
        for (int n = 0; n < NUM_DIRECTED; n++) begin
            srow   = DIRECTED[n];
            answer = '{srow.code, srow.row, srow.col, 8'd0, 1'b0, srow.px, srow.py, 1'b1};
            offer_byte(srow.ch, srow.fixed, answer);
        end
        i_in_valid <= 1'b0;
        wait_quiet();

        // random phases, each with its own geometry and idle pattern
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == 2) write_reg(CFG_SPARE, 8'($urandom));
            write_reg(CFG_ROWS, PHASE_ROWS[ph]);
            write_reg(CFG_COLS, PHASE_COLS[ph]);
            i_cfg_valid <= 1'b0;
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            // long output hold while bytes keep coming: the block must back up
            if (ph == 4) hold_pending = 1'b1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // sender pauses until the block has drained
                if (ph == 5 && k == ITEMS_PER_PHASE / 2) begin
                    i_in_valid <= 1'b0;
                    do @(posedge i_clk); while (pending_cmds.size() != 0);
                end
                if (locate_args.size() != 0) begin
                    ch = locate_args.pop_front();
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 45) begin
                        ch = 8'($urandom_range(PRINT_LO, PRINT_HI));
                    end else if (pick < 80) begin
                        ch = 8'($urandom_range(CH_HOME, CH_DEL));
                    end else if (pick < 88) begin
                        ch = CH_LOCATE;
                        locate_args.push_back(locate_arg(rows_eff()));
                        locate_args.push_back(locate_arg(cols_eff()));
                    end else begin
                        // unprintable: 0, 18..31, 0xfe, 0xff
                        ch = 8'($urandom_range(0, 16));
                        if (ch == 0) ch = 8'h00;
                        else if (ch < 3) ch = 8'hfd + ch;
                        else ch = 8'd15 + ch;
                    end
                end
                offer_byte(ch, 1'b0, '0);
            end
            i_in_valid <= 1'b0;
            wait_quiet();
        end

        if (mismatches == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/tcci_pkg.sv
sv/tcci_step.sv
sv/text_console_control_interpreter.sv
dv/tb_text_console_control_interpreter.sv
